// ----- rtl/core/neuron_mac_sigmoid_macros.svh -----
// Assertion macros shared by the neuron MAC/sigmoid RTL.
`ifndef NEURON_MAC_SIGMOID_MACROS_SVH
`define NEURON_MAC_SIGMOID_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NMS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define NMS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/nms_pkg.sv -----
// Constants and sigmoid table builder for the neuron MAC/sigmoid block.
package nms_pkg;

   localparam int NMS_SIGMOID_ENTRIES = 256;
   localparam int NMS_DATA_WIDTH      = 16;

   localparam int ACC_W      = 48;   // accumulator, Q24.24
   localparam int SUM_FRAC   = 24;
   localparam int SAT_BIT    = 27;   // saturation limit 2^27 (= 8.0 in Q24.24)
   localparam int ADDR_SHIFT = 28;
   localparam int TBL_Q      = 30;
   localparam int OUT_W      = 16;

   localparam int RSP_DEPTH = 8;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // restoring divide, elaboration only
   function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      int          b;
      rem = '0;
      quo = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // rounded 65536*sigmoid(x) at the midpoint of bin idx of n over [-8,8)
   function automatic logic [OUT_W-1:0] sig_entry(int idx, int n);
      logic signed [63:0] m;
      logic [63:0]        am;
      logic [63:0]        term;
      logic [63:0]        acc;
      logic [63:0]        e;
      logic [63:0]        den;
      logic [63:0]        val;
      int                 k;
      m    = 64'(2 * idx + 1) - 64'(n);
      am   = (m < 0) ? 64'(-m) : 64'(m);
      term = 64'(1) << TBL_Q;
      acc  = term;
      for (k = 1; k <= 24; k++) begin
         term = udiv64(term * am, 64'(2) * 64'(n) * 64'(k));
         if (k % 2 == 1) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      e = acc;
      for (k = 0; k < 4; k++) begin
         e = (e * e + (64'(1) << (TBL_Q - 1))) >> TBL_Q;
      end
      den = (64'(1) << TBL_Q) + e;
      if (m >= 0) begin
         val = udiv64((64'(1) << (TBL_Q + 16)) + (den >> 1), den);
      end else begin
         val = udiv64((e << 16) + (den >> 1), den);
      end
      if (val > 64'(65535)) begin
         val = 64'(65535);
      end
      return val[OUT_W-1:0];
   endfunction

endpackage

// ----- rtl/core/neuron_mac_sigmoid.sv -----
// Neuron forward path: multiply-accumulate over a fan-in, then table sigmoid.
//
//   Channel   Dir   Handshake                Carries
//   req_*     in    req_tvalid/req_tready    tdata: activation, weight; tlast: last
//   rsp_*     out   rsp_tvalid/rsp_tready    tdata: neuron_out (Q0.16)
//   csr_*     in    csr_valid/csr_ready      data: bias_term (Q4.12)
//
// One word is taken per cycle while req_tready is high; the multiply-accumulate
// loop closes in a single 48-bit add. A last word's result passes through the
// operand, product, sum, clamp and ROM registers, is written into the result
// queue and is read from it into the rsp output register.
// Reset is synchronous and active high; it arms a fresh sum from the bias.
// req_tready drops only while eight results are owed and not yet taken, which
// bounds the result queue; rsp_tready never reaches req_tready combinationally.
`include "neuron_mac_sigmoid_macros.svh"

module neuron_mac_sigmoid
   import nms_pkg::*;
#(
   parameter int SIGMOID_ENTRIES = NMS_SIGMOID_ENTRIES,
   parameter int DATA_WIDTH      = NMS_DATA_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // input words
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [DATA_WIDTH-1:0] activation, [2*DATA_WIDTH-1:DATA_WIDTH] weight, zero pad
   input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]     req_tdata,
   input  logic                                  req_tlast,
   // result words
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [15:0] neuron_out
   output logic [OUT_W-1:0]                      rsp_tdata,
   // bias register write
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [DATA_WIDTH-1:0]                 csr_data
);

   localparam int ADDR_W  = $clog2(SIGMOID_ENTRIES);
   localparam int PROD_W  = 2 * DATA_WIDTH;
   localparam int EXT_W   = ACC_W + 2 * DATA_WIDTH;
   // product is Q(2*(DW-4)) fraction, bias is Q(DW-4); align both to Q24
   localparam int PROD_SH = SUM_FRAC - 2 * (DATA_WIDTH - 4);
   localparam int BIAS_SH = SUM_FRAC - (DATA_WIDTH - 4);
   localparam int PROD_L  = (PROD_SH > 0) ? PROD_SH : 0;
   localparam int PROD_R  = (PROD_SH < 0) ? -PROD_SH : 0;
   localparam int BIAS_L  = (BIAS_SH > 0) ? BIAS_SH : 0;
   localparam int BIAS_R  = (BIAS_SH < 0) ? -BIAS_SH : 0;
   localparam int IDX_W   = ADDR_SHIFT + ADDR_W + 1;

   // sigmoid ROM, built at elaboration
   typedef logic [OUT_W-1:0] rom_type [SIGMOID_ENTRIES];

   function automatic rom_type build_rom();
      rom_type r;
      for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
         r[i] = sig_entry(i, SIGMOID_ENTRIES);
      end
      return r;
   endfunction

   localparam rom_type SIG_ROM = build_rom();
   localparam logic [ADDR_W:0] ENTRIES_V = (ADDR_W + 1)'(SIGMOID_ENTRIES);

   logic                         req_acc;
   logic                         rsp_acc;

   logic [DATA_WIDTH-1:0]        bias_ff;

   // stage 1: captured operands
   logic                         s1_vld_ff;
   logic                         s1_last_ff;
   logic signed [DATA_WIDTH-1:0] act_ff;
   logic signed [DATA_WIDTH-1:0] wgt_ff;

   // stage 2: raw product
   logic                         s2_vld_ff;
   logic                         s2_last_ff;
   logic signed [PROD_W-1:0]     prod_ff;

   // stage 3: accumulator
   logic [ACC_W-1:0]             acc_ff;
   logic [ACC_W-1:0]             acc_in;
   logic                         fresh_ff;
   logic                         s3_vld_ff;

   // stage 4: saturated, offset sum
   logic                         s4_vld_ff;
   logic [ADDR_SHIFT-1:0]        ofs_ff;
   logic [ADDR_SHIFT-1:0]        ofs_in;

   // stage 5: ROM data
   logic                         s5_vld_ff;
   logic [OUT_W-1:0]             rom_q_ff;
   logic [IDX_W-1:0]             scaled;
   logic [ADDR_W-1:0]            rom_addr;

   // result queue and its output register
   logic [OUT_W-1:0]             rq_mem [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]         rq_wr_ff;
   logic [RSP_PTR_W-1:0]         rq_rd_ff;
   logic [RSP_CNT_W-1:0]         rq_cnt_ff;   // words held in rq_mem
   logic [RSP_CNT_W-1:0]         pend_ff;
   logic                         rq_load;
   logic                         out_vld_ff;
   logic [OUT_W-1:0]             out_data_ff;

   logic signed [EXT_W-1:0]      prod_ext;
   logic signed [EXT_W-1:0]      prod_al;
   logic signed [EXT_W-1:0]      bias_ext;
   logic signed [EXT_W-1:0]      bias_al;
   logic [ACC_W-1:0]             base;

   assign req_acc    = req_tvalid && req_tready;
   assign rsp_acc    = rsp_tvalid && rsp_tready;
   // hold off new words only when every queue slot is already promised
   assign req_tready = (pend_ff < RSP_CNT_W'(RSP_DEPTH));
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   // refill the output register when it is empty or its word is being taken
   assign rq_load    = (rq_cnt_ff != '0) && (!out_vld_ff || rsp_acc);

   // bias register
   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         bias_ff <= csr_data;
      end
   end

   // stage 1: capture operands
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= req_acc;
      end
      if (req_acc) begin
         act_ff     <= req_tdata[DATA_WIDTH-1:0];
         wgt_ff     <= req_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
         s1_last_ff <= req_tlast;
      end
   end

   // stage 2: multiply
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      if (s1_vld_ff) begin
         prod_ff    <= act_ff * wgt_ff;
         s2_last_ff <= s1_last_ff;
      end
   end

   // stage 3: align and accumulate; a fresh sum starts from the bias
   always_comb begin
      prod_ext = {{(EXT_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      prod_al  = (prod_ext <<< PROD_L) >>> PROD_R;
      bias_ext = {{(EXT_W-DATA_WIDTH){bias_ff[DATA_WIDTH-1]}}, bias_ff};
      bias_al  = (bias_ext <<< BIAS_L) >>> BIAS_R;
      base     = fresh_ff ? bias_al[ACC_W-1:0] : acc_ff;
      acc_in   = base + prod_al[ACC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff  <= 1'b1;
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff && s2_last_ff;
         if (s2_vld_ff) begin
            fresh_ff <= s2_last_ff;
         end
      end
      if (s2_vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   // stage 4: clamp to [-8,8) and offset to an unsigned 28-bit position
   always_comb begin
      if (acc_ff[ACC_W-1:SAT_BIT] == '0 || acc_ff[ACC_W-1:SAT_BIT] == '1) begin
         ofs_in = {~acc_ff[SAT_BIT], acc_ff[SAT_BIT-1:0]};
      end else if (acc_ff[ACC_W-1]) begin
         ofs_in = '0;
      end else begin
         ofs_in = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s3_vld_ff;
      end
      if (s3_vld_ff) begin
         ofs_ff <= ofs_in;
      end
   end

   // stage 5: scale to a table index and read the ROM
   always_comb begin
      scaled   = IDX_W'(ofs_ff) * IDX_W'(ENTRIES_V);
      rom_addr = scaled[ADDR_SHIFT +: ADDR_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else begin
         s5_vld_ff <= s4_vld_ff;
      end
      if (s4_vld_ff) begin
         rom_q_ff <= SIG_ROM[rom_addr];
      end
   end

   // result queue: push from the ROM stage, read into the output register
   always_ff @(posedge clock) begin
      if (s5_vld_ff) begin
         rq_mem[rq_wr_ff] <= rom_q_ff;
      end
      if (rq_load) begin
         out_data_ff <= rq_mem[rq_rd_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff   <= '0;
         rq_rd_ff   <= '0;
         rq_cnt_ff  <= '0;
         pend_ff    <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         if (s5_vld_ff) begin
            rq_wr_ff <= rq_wr_ff + 1'b1;
         end
         if (rq_load) begin
            rq_rd_ff <= rq_rd_ff + 1'b1;
         end
         case ({s5_vld_ff, rq_load})
            2'b10:   rq_cnt_ff <= rq_cnt_ff + 1'b1;
            2'b01:   rq_cnt_ff <= rq_cnt_ff - 1'b1;
            default: rq_cnt_ff <= rq_cnt_ff;
         endcase
         if (rq_load) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_acc) begin
            out_vld_ff <= 1'b0;
         end
         case ({req_acc && req_tlast, rsp_acc})
            2'b10:   pend_ff <= pend_ff + 1'b1;
            2'b01:   pend_ff <= pend_ff - 1'b1;
            default: pend_ff <= pend_ff;
         endcase
      end
   end

   `NMS_ASSERT_NOW(a_pend_bound, clock, reset, 1'b1, pend_ff <= RSP_CNT_W'(RSP_DEPTH),
      "owed results exceed queue depth")
   `NMS_ASSERT_NOW(a_cnt_le_pend, clock, reset, 1'b1,
      (rq_cnt_ff + RSP_CNT_W'(out_vld_ff)) <= pend_ff, "queued results exceed owed results")
   `NMS_ASSERT_NOW(a_no_overflow, clock, reset, s5_vld_ff,
      rq_cnt_ff < RSP_CNT_W'(RSP_DEPTH), "result queue overflow")
   `NMS_ASSERT_NEXT(a_pend_inc, clock, reset, req_acc && req_tlast && !rsp_acc,
      pend_ff == $past(pend_ff) + 1'b1, "last word did not reserve a result slot")

endmodule
